@@ sv/gnfbm_pkg.sv @@
// Shared types and fixed-point constants of the fractal gradient noise core.
package gnfbm_pkg;

	// Internal fraction width of offsets, fades and lerps
	localparam int FRAC_BITS = 16;
	localparam int ONE       = 1 << FRAC_BITS;

	// Sample position: 8 cell bits over 32 fraction bits
	localparam int POS_W = 40;

	// 0.7071 in Q0.16
	localparam int SCALE_Q16 = 46340;

	// Output saturation limits, Q2.16
	localparam int OUT_MAX = 131071;
	localparam int OUT_MIN = -131072;

	// Quotient magnitude bits of the normalising divide
	localparam int QUO_W = 20;

	typedef enum logic {
		OP_EVAL = 1'b0,
		OP_LOAD = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		CFG_OCTAVE_COUNT = 2'd0,
		CFG_BASE_FREQ    = 2'd1,
		CFG_OCTAVE_GAIN  = 2'd2
	} cfg_index_t;

endpackage

@@ sv/gnfbm_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module gnfbm_div #(
	parameter int DVD_W = 39,
	parameter int DVS_W = 21,
	parameter int QUO_W = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [DVD_W-1:0] dividend,
	input  logic        [DVS_W-1:0] divisor,
	output logic                    done,
	output logic signed [QUO_W:0]   quotient
);
	localparam int W     = (DVD_W > DVS_W + QUO_W) ? DVD_W : DVS_W + QUO_W;
	localparam int CNT_W = $clog2(QUO_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     dvs_q;
	logic [QUO_W-1:0] quo_q;
	logic             neg_q;
	logic [DVD_W-1:0] mag;

	// Take the magnitude of the dividend
	always_comb begin
		mag = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
	end

	// Control: count the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: compare, subtract and shift the divisor down
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= W'(mag);
			dvs_q <= W'(divisor) << (QUO_W - 1);
			quo_q <= '0;
			neg_q <= dividend[DVD_W-1];
		end else if (busy_q) begin
			if (rem_q >= dvs_q) begin
				rem_q <= rem_q - dvs_q;
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			dvs_q <= dvs_q >> 1;
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divide started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done held longer than a cycle");
	a_busy_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0) else $error("busy with no bits left");

endmodule

@@ sv/gradient_noise_fbm_2d_core.sv @@
// Top level of the 2D fractal gradient noise core.
// A load word writes one byte of the 256-entry permutation table.
// An evaluate word sums N octaves (N = 0 gives 0): each octave is an eight-step
// sequence around the dual-read permutation table (three rounds of two reads,
// gradient lerps, scaling and weighted accumulation), and the final
// normalisation is a 20-bit bit-serial divider that holds the sequence until
// its quotient is done. One word is worked at a time; a finished result sits
// in the output register while the next word is taken.
// Unwritten table entries read as undefined.
module gradient_noise_fbm_2d_core #(
	parameter int MAX_OCTAVES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               opcode,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic        [7:0]  table_index,
	input  logic        [7:0]  table_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [17:0] noise_value,
	input  logic               cfg_we,
	input  logic        [1:0]  cfg_index,
	input  logic        [23:0] cfg_wdata
);
	import gnfbm_pkg::*;

	localparam int OCT_W  = $clog2(MAX_OCTAVES + 1);
	localparam int WP_W   = 38;
	localparam int SUM_W  = WP_W + OCT_W;
	localparam int NORM_W = 17 + OCT_W;

	typedef enum logic [3:0] {
		S_IDLE, S_POS, S_FETCH, S_ROW0, S_ROW1, S_GRAD,
		S_LERPY, S_SCALE, S_ACCUM, S_SUM, S_DIV, S_OUT
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [3:0]  octave_count_q;
	logic [23:0] base_frequency_q;
	logic [16:0] octave_gain_q;

	// Evaluation registers
	logic signed [31:0]       x_q, y_q;
	logic [OCT_W-1:0]         oct_lim_q, oct_idx_q;
	logic [16:0]              gain_q, amp_q;
	logic [POS_W-1:0]         pos_x_q, pos_y_q;
	logic [15:0]              tt_x_s1, tt_y_s1, t3_x_s2, t3_y_s2;
	logic [19:0]              b_x_s1, b_y_s1;
	logic [16:0]              u_s3, v_s3;
	logic [7:0]               p1_q, aa_q, ab_q;
	logic signed [19:0]       ix0_s4, ix1_s4, r_s5, on_s6;
	logic signed [WP_W-1:0]   wprod_s7;
	logic signed [SUM_W-1:0]  sum_q;
	logic [NORM_W-1:0]        norm_q;
	logic signed [17:0]       result_q, noise_q;
	logic                     out_valid_q;

	// Permutation table
	logic [7:0] perm_mem [256];
	logic [7:0] rd_a_q, rd_b_q, ra, rb;
	logic       mem_we;

	logic [15:0] fx, fy;
	logic [7:0]  cx, cy;
	logic        accept, div_start, div_done;
	logic signed [QUO_W:0] div_quo;

	logic [OCT_W-1:0] oct_lim_in;
	logic [16:0]      gain_in;
	logic [56:0]      px_full, py_full;
	logic [31:0]      sq_x, sq_y, c3_x, c3_y;
	logic signed [20:0] lin_x, lin_y;
	logic signed [37:0] bp_x, bp_y;
	logic signed [21:0] bs_x, bs_y;
	logic [35:0]      fp_x, fp_y;
	logic signed [19:0] n00, n10, n01, n11;
	logic signed [37:0] sc_p;
	logic [33:0]      amp_p;

	// Quintic fade first stage: linear factor of the polynomial tail
	function automatic logic signed [20:0] fade_lin(input logic [15:0] t);
		logic [20:0] six_t;
		six_t = 21'(t) * 21'd6;
		return $signed(six_t - 21'(15 * ONE));
	endfunction

	// Gradient dot product over the four diagonals
	function automatic logic signed [19:0] grad(input logic [1:0] h,
			input logic signed [17:0] dx, input logic signed [17:0] dy);
		logic signed [19:0] ex, ey, g;
		ex = 20'(dx);
		ey = 20'(dy);
		case (h)
			2'd0:    g = ex + ey;
			2'd1:    g = ey - ex;
			2'd2:    g = ex - ey;
			default: g = -ex - ey;
		endcase
		return g;
	endfunction

	// Linear interpolation a + floor((b - a) * t)
	function automatic logic signed [19:0] lerp(input logic signed [19:0] a,
			input logic signed [19:0] b, input logic [16:0] t);
		logic signed [20:0] d;
		logic signed [38:0] p;
		logic signed [22:0] s;
		d = 21'(b) - 21'(a);
		p = d * $signed({1'b0, t});
		s = 23'(a) + p[38:16];
		return s[19:0];
	endfunction

	assign accept    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign mem_we    = accept && (opcode == OP_LOAD);
	assign out_valid = out_valid_q;
	assign noise_value = noise_q;

	assign cx = pos_x_q[POS_W-1:32];
	assign cy = pos_y_q[POS_W-1:32];
	assign fx = pos_x_q[31:32-FRAC_BITS];
	assign fy = pos_y_q[31:32-FRAC_BITS];

	// Clamp the octave count and gain as an evaluate word is taken
	always_comb begin
		oct_lim_in = (int'(octave_count_q) > MAX_OCTAVES) ?
			OCT_W'(MAX_OCTAVES) : OCT_W'(octave_count_q);
		gain_in = (octave_gain_q > 17'(ONE)) ? 17'(ONE) : octave_gain_q;
	end

	// Table read addresses for each fetch round
	always_comb begin
		case (state_q)
			S_ROW0: begin
				ra = rd_a_q + cy;
				rb = rd_a_q + cy + 8'd1;
			end
			S_ROW1: begin
				ra = p1_q + cy;
				rb = p1_q + cy + 8'd1;
			end
			default: begin
				ra = cx;
				rb = cx + 8'd1;
			end
		endcase
	end

	// Permutation table: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (mem_we)
			perm_mem[table_index] <= table_value;
		rd_a_q <= perm_mem[ra];
		rd_b_q <= perm_mem[rb];
	end

	// Arithmetic of each step
	always_comb begin
		px_full = x_q * $signed({1'b0, base_frequency_q});
		py_full = y_q * $signed({1'b0, base_frequency_q});
		sq_x    = fx * fx;
		sq_y    = fy * fy;
		lin_x   = fade_lin(fx);
		lin_y   = fade_lin(fy);
		bp_x    = lin_x * $signed({1'b0, fx});
		bp_y    = lin_y * $signed({1'b0, fy});
		bs_x    = bp_x[37:16] + 22'(10 * ONE);
		bs_y    = bp_y[37:16] + 22'(10 * ONE);
		c3_x    = tt_x_s1 * fx;
		c3_y    = tt_y_s1 * fy;
		fp_x    = t3_x_s2 * b_x_s1;
		fp_y    = t3_y_s2 * b_y_s1;
		n00 = grad(aa_q[1:0], $signed({2'b0, fx}), $signed({2'b0, fy}));
		n10 = grad(rd_a_q[1:0], $signed({2'b0, fx}) - 18'sd65536,
			$signed({2'b0, fy}));
		n01 = grad(ab_q[1:0], $signed({2'b0, fx}),
			$signed({2'b0, fy}) - 18'sd65536);
		n11 = grad(rd_b_q[1:0], $signed({2'b0, fx}) - 18'sd65536,
			$signed({2'b0, fy}) - 18'sd65536);
		sc_p  = r_s5 * $signed(18'(SCALE_Q16));
		amp_p = amp_q * gain_q;
	end

	assign div_start = (state_q == S_SUM) && (oct_idx_q == oct_lim_q - 1'b1);

	// Sequencer, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			out_valid_q      <= 1'b0;
			octave_count_q   <= 4'd1;
			base_frequency_q <= 24'(ONE);
			octave_gain_q    <= 17'd32768;
			oct_idx_q        <= '0;
			oct_lim_q        <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_OCTAVE_COUNT: octave_count_q   <= cfg_wdata[3:0];
					CFG_BASE_FREQ:    base_frequency_q <= cfg_wdata;
					CFG_OCTAVE_GAIN:  octave_gain_q    <= cfg_wdata[16:0];
					default: ;
				endcase
			end
			if (out_valid_q && out_ready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept && opcode == OP_EVAL) begin
						oct_lim_q <= oct_lim_in;
						oct_idx_q <= '0;
						state_q   <= (oct_lim_in == '0) ? S_OUT : S_POS;
					end
				end
				S_POS:   state_q <= S_FETCH;
				S_FETCH: state_q <= S_ROW0;
				S_ROW0:  state_q <= S_ROW1;
				S_ROW1:  state_q <= S_GRAD;
				S_GRAD:  state_q <= S_LERPY;
				S_LERPY: state_q <= S_SCALE;
				S_SCALE: state_q <= S_ACCUM;
				S_ACCUM: state_q <= S_SUM;
				S_SUM: begin
					oct_idx_q <= oct_idx_q + 1'b1;
					state_q   <= div_start ? S_DIV : S_FETCH;
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q      <= coord_x;
				y_q      <= coord_y;
				gain_q   <= gain_in;
				result_q <= '0;
			end
			S_POS: begin
				pos_x_q <= px_full[POS_W-1:0];
				pos_y_q <= py_full[POS_W-1:0];
				amp_q   <= 17'(ONE);
				sum_q   <= '0;
				norm_q  <= '0;
			end
			S_FETCH: begin
				tt_x_s1 <= sq_x[31:16];
				tt_y_s1 <= sq_y[31:16];
				b_x_s1  <= bs_x[19:0];
				b_y_s1  <= bs_y[19:0];
			end
			S_ROW0: begin
				p1_q    <= rd_b_q;
				t3_x_s2 <= c3_x[31:16];
				t3_y_s2 <= c3_y[31:16];
			end
			S_ROW1: begin
				aa_q <= rd_a_q;
				ab_q <= rd_b_q;
				u_s3 <= fp_x[32:16];
				v_s3 <= fp_y[32:16];
			end
			S_GRAD: begin
				ix0_s4 <= lerp(n00, n10, u_s3);
				ix1_s4 <= lerp(n01, n11, u_s3);
			end
			S_LERPY: r_s5 <= lerp(ix0_s4, ix1_s4, v_s3);
			S_SCALE: on_s6 <= sc_p[35:16];
			S_ACCUM: begin
				wprod_s7 <= on_s6 * $signed({1'b0, amp_q});
				norm_q   <= norm_q + NORM_W'(amp_q);
				amp_q    <= amp_p[32:16];
			end
			S_SUM: begin
				sum_q   <= sum_q + SUM_W'(wprod_s7);
				pos_x_q <= pos_x_q << 1;
				pos_y_q <= pos_y_q << 1;
			end
			S_DIV: begin
				if (div_done) begin
					if (div_quo > (QUO_W+1)'(OUT_MAX))
						result_q <= 18'(OUT_MAX);
					else if (div_quo < (QUO_W+1)'(OUT_MIN))
						result_q <= 18'(OUT_MIN);
					else
						result_q <= div_quo[17:0];
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready)
					noise_q <= result_q;
			end
			default: ;
		endcase
	end

	// Normalise the weighted sum by the amplitude total
	gnfbm_div #(
		.DVD_W (SUM_W),
		.DVS_W (NORM_W),
		.QUO_W (QUO_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q + SUM_W'(wprod_s7)),
		.divisor  (norm_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	a_eval_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_EVAL) |=> (state_q == S_POS || state_q == S_OUT))
		else $error("evaluate word did not start a run");
	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_LOAD) |=> state_q == S_IDLE)
		else $error("load word left idle");
	a_octave_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |-> oct_idx_q < oct_lim_q)
		else $error("octave index past limit");
	a_amp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACCUM) |-> amp_q <= 17'(ONE))
		else $error("amplitude above one");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divide finished outside the divide wait");

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the 2D fractal gradient noise core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import gnfbm_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;	// no register behind this index
	localparam int         SETTLE    = 100;		// longer than one full evaluate

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               opcode;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic        [7:0]  table_index;
	logic        [7:0]  table_value;
	logic               out_valid;
	logic               out_ready;
	logic signed [17:0] noise_value;
	logic               cfg_we;
	logic        [1:0]  cfg_index;
	logic        [23:0] cfg_wdata;

	gradient_noise_fbm_2d_core u_dut (.*);

	// Mirror of the block state
	logic [7:0]  perm_mirror [256];
	logic [3:0]  octaves_set;
	logic [23:0] freq_set;
	logic [16:0] gain_set;

	logic signed [17:0] noise_due [$];
	int                 err_count;
	bit                 tx_bursts;
	bit                 rx_bursts;
	bit                 rx_hold;

	typedef struct {
		opcode_t            op;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic        [7:0]  idx;
		logic        [7:0]  val;
		bit                 known;
		logic signed [17:0] noise;
	} stim_row_t;

	stim_row_t directed [$];

	// Fixed-point helpers
	function automatic longint fade(longint t);
		longint b, t3;
		b  = (((6 * t - 15 * ONE) * t) >>> FRAC_BITS) + 10 * ONE;
		t3 = ((((t * t) >>> FRAC_BITS) * t) >>> FRAC_BITS);
		return (t3 * b) >>> FRAC_BITS;
	endfunction

	function automatic longint blend(longint a, longint b, longint t);
		return a + (((b - a) * t) >>> FRAC_BITS);
	endfunction

	function automatic longint slope(logic [7:0] h, longint dx, longint dy);
		case (h[1:0])
			2'd0: return dx + dy;
			2'd1: return -dx + dy;
			2'd2: return dx - dy;
			default: return -dx - dy;
		endcase
	endfunction

	function automatic longint octave_noise(logic [63:0] px, logic [63:0] py);
		logic [7:0] cx, cy, cx1, p0, p1, i0, i1, i2, i3;
		longint     fx, fy, u, v, ix0, ix1;
		cx  = px[39:32];
		cy  = py[39:32];
		fx  = longint'({48'd0, px[31:16]});
		fy  = longint'({48'd0, py[31:16]});
		u   = fade(fx);
		v   = fade(fy);
		cx1 = cx + 8'd1;
		p0  = perm_mirror[cx];
		p1  = perm_mirror[cx1];
		i0  = p0 + cy;
		i1  = p0 + cy + 8'd1;
		i2  = p1 + cy;
		i3  = p1 + cy + 8'd1;
		ix0 = blend(slope(perm_mirror[i0], fx, fy), slope(perm_mirror[i2], fx - ONE, fy), u);
		ix1 = blend(slope(perm_mirror[i1], fx, fy - ONE),
			slope(perm_mirror[i3], fx - ONE, fy - ONE), u);
		return (blend(ix0, ix1, v) * SCALE_Q16) >>> 16;
	endfunction

	// Normalised fractal sum at one point
	function automatic logic signed [17:0] fbm_noise(logic signed [31:0] x,
			logic signed [31:0] y);
		logic [63:0] xu, yu;
		longint      sum, norm, amp, g, q;
		int          n;
		n    = (octaves_set > 4'd8) ? 8 : int'(octaves_set);
		g    = (gain_set > 17'd65536) ? 65536 : longint'({47'd0, gain_set});
		xu   = {{32{x[31]}}, x} * {40'd0, freq_set};
		yu   = {{32{y[31]}}, y} * {40'd0, freq_set};
		sum  = 0;
		norm = 0;
		amp  = 65536;
		for (int i = 0; i < n; i++) begin
			sum  += amp * octave_noise(xu << i, yu << i);
			norm += amp;
			amp   = (amp * g) >>> 16;
		end
		q = (norm == 0) ? 0 : sum / norm;
		if (q > OUT_MAX) q = OUT_MAX;
		if (q < OUT_MIN) q = OUT_MIN;
		return q[17:0];
	endfunction

	task automatic flag_mismatch(string what);
		$display("tb_top: mismatch: %s", what);
		err_count++;
	endtask

	// Offer one word, hold it until taken, then predict
	task automatic send_word(opcode_t op, logic signed [31:0] x, logic signed [31:0] y,
			logic [7:0] idx, logic [7:0] val);
		@(negedge clk);
		if (tx_bursts && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		opcode      = op;
		coord_x     = x;
		coord_y     = y;
		table_index = idx;
		table_value = val;
		in_valid    = 1'b1;
		do @(posedge clk); while (!in_ready);
		if (op == OP_LOAD)
			perm_mirror[idx] = val;
		else
			noise_due.push_back(fbm_noise(x, y));
	endtask

	// Drop the offer, drain, settle, then write one register
	task automatic write_reg(logic [1:0] idx, logic [23:0] data);
		@(negedge clk);
		in_valid = 1'b0;
		wait (noise_due.size() == 0);
		repeat (SETTLE) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		case (idx)
			CFG_OCTAVE_COUNT: octaves_set = data[3:0];
			CFG_BASE_FREQ:    freq_set    = data;
			CFG_OCTAVE_GAIN:  gain_set    = data[16:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic random_words(int count);
		logic signed [31:0] x, y;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 1)) begin
				x = $urandom;
				y = $urandom;
			end else begin
				x = $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
				y = $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
			end
			if ($urandom_range(0, 9) < 7)
				send_word(OP_EVAL, x, y, 8'd0, 8'd0);
			else
				send_word(OP_LOAD, x, y, 8'($urandom), 8'($urandom));
		end
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("tb_top: errors");
		$finish;
	end

	// Result side: random stalls, one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold) begin
				out_ready = 1'b0;
				repeat (400) @(negedge clk);
				rx_hold = 1'b0;
			end else if (rx_bursts && $urandom_range(0, 3) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	// Check each word taken from the output
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (noise_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected result %0d", noise_value));
			end else begin
				if (noise_value !== noise_due[0])
					flag_mismatch($sformatf("noise_value %0d, want %0d",
						noise_value, noise_due[0]));
				void'(noise_due.pop_front());
			end
		end
	end

	// Stimulus
	initial begin
		logic [7:0] shuffle [256];
		logic [7:0] tmp;
		int         j;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		opcode      = OP_EVAL;
		coord_x     = '0;
		coord_y     = '0;
		table_index = '0;
		table_value = '0;
		cfg_we      = 1'b0;
		cfg_index   = CFG_OCTAVE_COUNT;
		cfg_wdata   = '0;
		err_count   = 0;
		tx_bursts   = 1'b1;
		rx_bursts   = 1'b1;
		rx_hold     = 1'b0;
		octaves_set = 4'd1;
		freq_set    = 24'd65536;
		gain_set    = 17'd32768;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Fill the whole table with a random permutation first
		for (int i = 0; i < 256; i++) shuffle[i] = 8'(i);
		for (int i = 255; i > 0; i--) begin
			j          = $urandom_range(0, i);
			tmp        = shuffle[i];
			shuffle[i] = shuffle[j];
			shuffle[j] = tmp;
		end
		for (int i = 0; i < 256; i++) send_word(OP_LOAD, 0, 0, 8'(i), shuffle[i]);

		// Directed rows: integer points give zero at any table
		directed = '{
			'{OP_EVAL, 32'sh0000_0000, 32'sh0000_0000, 8'd0, 8'd0, 1, 18'sd0},
			'{OP_EVAL, 32'sh7fff_0000, 32'sh8000_0000, 8'd0, 8'd0, 1, 18'sd0},
			'{OP_EVAL, 32'sh0003_0000, 32'shfffd_0000, 8'd0, 8'd0, 1, 18'sd0},
			'{OP_EVAL, 32'sh7fff_ffff, 32'sh7fff_ffff, 8'd0, 8'd0, 0, 18'sd0},
			'{OP_EVAL, 32'sh8000_0000, 32'sh7fff_ffff, 8'd0, 8'd0, 0, 18'sd0},
			'{OP_EVAL, 32'sh0000_8000, 32'sh0000_8000, 8'd0, 8'd0, 0, 18'sd0},
			'{OP_EVAL, 32'shffff_ffff, 32'sh0000_0001, 8'd0, 8'd0, 0, 18'sd0},
			'{OP_EVAL, 32'sh0000_ffff, 32'shffff_0001, 8'd0, 8'd0, 0, 18'sd0},
			'{OP_LOAD, 32'sh0, 32'sh0, 8'd0,   8'd255, 0, 18'sd0},
			'{OP_LOAD, 32'sh0, 32'sh0, 8'd255, 8'd0,   0, 18'sd0},
			'{OP_EVAL, 32'sh0000_4000, 32'shffff_c000, 8'd0, 8'd0, 0, 18'sd0},
			'{OP_EVAL, 32'sh00ff_c000, 32'sh00ff_4000, 8'd0, 8'd0, 0, 18'sd0},
			'{OP_EVAL, 32'sh0001_0000, 32'sh0000_0000, 8'd0, 8'd0, 1, 18'sd0}
		};
		foreach (directed[k]) begin
			send_word(directed[k].op, directed[k].x, directed[k].y,
				directed[k].idx, directed[k].val);
			if (directed[k].known && directed[k].noise !== noise_due[$])
				flag_mismatch($sformatf("directed row %0d predicts %0d", k, noise_due[$]));
		end

		// Zero octaves, then too many with gain above one and extreme frequency
		write_reg(CFG_OCTAVE_COUNT, 24'd0);
		random_words(10);
		write_reg(CFG_OCTAVE_COUNT, 24'd15);
		write_reg(CFG_BASE_FREQ, 24'hff_ffff);
		write_reg(CFG_OCTAVE_GAIN, 24'h01_ffff);
		write_reg(CFG_SPARE, 24'hff_ffff);
		random_words(25);

		// Full octaves, unity gain; receiver holds off while words pile up
		write_reg(CFG_OCTAVE_COUNT, 24'd8);
		write_reg(CFG_BASE_FREQ, 24'd65536);
		write_reg(CFG_OCTAVE_GAIN, 24'd65536);
		rx_hold = 1'b1;
		random_words(30);

		// Zero gain and near-zero frequency; sender waits for a full drain mid-way
		write_reg(CFG_OCTAVE_GAIN, 24'd0);
		write_reg(CFG_BASE_FREQ, 24'd1);
		random_words(20);
		@(negedge clk);
		in_valid = 1'b0;
		wait (noise_due.size() == 0);
		random_words(20);

		// Random settings
		for (int p = 0; p < 3; p++) begin
			write_reg(CFG_OCTAVE_COUNT, 24'($urandom_range(1, 8)));
			write_reg(CFG_BASE_FREQ, 24'($urandom_range(0, 24'h04_0000)));
			write_reg(CFG_OCTAVE_GAIN, 24'($urandom_range(0, 65536)));
			random_words(25);
		end

		// Back to reset values, last stretch at full rate
		write_reg(CFG_OCTAVE_COUNT, 24'd1);
		write_reg(CFG_BASE_FREQ, 24'd65536);
		write_reg(CFG_OCTAVE_GAIN, 24'd32768);
		tx_bursts = 1'b0;
		rx_bursts = 1'b0;
		random_words(40);

		@(negedge clk);
		in_valid = 1'b0;
		wait (noise_due.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
